// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL files, included by bwiir_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Clocked property that is also checked during reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/bwiir_pkg.sv -----
package bwiir_pkg;

    localparam int ORDER_DEF   = 4;
    localparam int NUM_FB      = 4;
    localparam int DATA_W      = 16;
    localparam int GAIN_W      = 32;
    localparam int COEF_W      = 32;
    localparam int HIST_W      = 32;
    localparam int MUL_A_W     = 33;
    localparam int PROD_W      = MUL_A_W + HIST_W;
    localparam int ACC_W       = 44;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int BINOM_W     = 5;
    localparam int SCALE_SHIFT = 18;
    localparam int FB_SHIFT    = 26;
    localparam int OUT_SHIFT   = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_4  = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h8000_0000;

    typedef enum logic [1:0] {
        TERM_SCALE,
        TERM_BINOM,
        TERM_FEEDBACK
    } term_kind_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;    // capture the input sample
        logic issue;   // multiply the operands of the current step
        logic accum;   // fold the registered product into the accumulator
        logic commit;  // saturate, shift the histories, load the output register
    } cmd_t;

    // Rows of Pascal's triangle for orders 0 to 6.
    localparam logic [BINOM_W-1:0] BINOM_ROWS [0:6][0:6] = '{
        '{5'd1, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd1, 5'd1, 5'd0,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd1, 5'd2, 5'd1,  5'd0,  5'd0,  5'd0, 5'd0},
        '{5'd1, 5'd3, 5'd3,  5'd1,  5'd0,  5'd0, 5'd0},
        '{5'd1, 5'd4, 5'd6,  5'd4,  5'd1,  5'd0, 5'd0},
        '{5'd1, 5'd5, 5'd10, 5'd10, 5'd5,  5'd1, 5'd0},
        '{5'd1, 5'd6, 5'd15, 5'd20, 5'd15, 5'd6, 5'd1}
    };

    function automatic logic [BINOM_W-1:0] binom_weight(input logic [2:0] order,
                                                        input logic [2:0] k);
        logic [BINOM_W-1:0] w;
        w = 5'd0;
        if (order <= 3'd6 && k <= 3'd6) begin
            w = BINOM_ROWS[order][k];
        end
        return w;
    endfunction

endpackage

// ----- rtl/core/bwiir_ctrl.sv -----
`include "assert_macros.svh"

module bwiir_ctrl #(
    parameter int ORDER = bwiir_pkg::ORDER_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output bwiir_pkg::cmd_t                       cmd,
    output logic [$clog2(2 * ORDER + 1) - 1:0]    step
);

    localparam int STEP_W = $clog2(2 * ORDER + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * ORDER);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               m_valid_reg, m_valid_next;
    logic               out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign step     = step_reg;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                cmd.issue = 1'b1;
                // The product of the previous step is folded in while this one multiplies.
                cmd.accum = (step_reg != '0);
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                cmd.accum  = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ASSERT_CLK(a_commit_needs_room, aclk, aresetn,
        cmd.commit |-> (!m_valid_reg || m_tready), "result overwritten before it was taken")
    `ASSERT_CLK(a_accept_starts_mac, aclk, aresetn,
        (s_tvalid && s_tready) |=> (state_reg == ST_MAC && step_reg == '0),
        "accepted request did not start the multiply sequence")
    `ASSERT_CLK(a_valid_from_commit, aclk, aresetn,
        $rose(m_valid_reg) |-> $past(cmd.commit), "result valid raised without a commit")

endmodule

// ----- rtl/core/bwiir_dp.sv -----
module bwiir_dp #(
    parameter int ORDER = bwiir_pkg::ORDER_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  bwiir_pkg::cmd_t                            cmd,
    input  logic [$clog2(2 * ORDER + 1) - 1:0]         step,
    input  logic                                       cfg_we,
    input  logic [bwiir_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [bwiir_pkg::CFG_DATA_W-1:0]           cfg_wdata,
    input  logic [bwiir_pkg::DATA_W-1:0]               s_data,
    output logic [bwiir_pkg::DATA_W-1:0]               m_data
);

    localparam int STEP_W    = $clog2(2 * ORDER + 1);
    localparam int NUM_TAPS  = 2 * ORDER;
    localparam int TAP_IDX_W = $clog2(NUM_TAPS);
    localparam int PROD_W    = bwiir_pkg::PROD_W;
    localparam int ACC_W     = bwiir_pkg::ACC_W;
    localparam int HIST_W    = bwiir_pkg::HIST_W;
    localparam int DATA_W    = bwiir_pkg::DATA_W;
    localparam int MUL_A_W   = bwiir_pkg::MUL_A_W;

    localparam logic signed [PROD_W-1:0] SCALE_HALF = PROD_W'(1) << (bwiir_pkg::SCALE_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] FB_HALF    = PROD_W'(1) << (bwiir_pkg::FB_SHIFT - 1);
    localparam logic signed [PROD_W-1:0] P_MAX      = PROD_W'(32'h7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] P_MIN      = ~P_MAX;
    localparam logic signed [ACC_W-1:0]  A_MAX      = ACC_W'(32'h7FFF_FFFF);
    localparam logic signed [ACC_W-1:0]  A_MIN      = ~A_MAX;
    localparam logic signed [HIST_W:0]   OUT_HALF   = (HIST_W + 1)'(1) << (bwiir_pkg::OUT_SHIFT - 1);
    localparam logic signed [HIST_W:0]   O_MAX      = (HIST_W + 1)'(16'h7FFF);
    localparam logic signed [HIST_W:0]   O_MIN      = ~O_MAX;

    logic [bwiir_pkg::GAIN_W-1:0]        gain_reg;
    logic signed [bwiir_pkg::COEF_W-1:0] coef_reg [0:bwiir_pkg::NUM_FB-1];
    logic signed [HIST_W-1:0]            tap_reg  [0:NUM_TAPS-1];
    logic signed [DATA_W-1:0]            sample_reg;
    logic signed [PROD_W-1:0]            prod_reg;
    bwiir_pkg::term_kind_t               kind_reg;
    logic signed [ACC_W-1:0]             acc_reg;
    logic signed [HIST_W-1:0]            xs_reg;
    logic [DATA_W-1:0]                   out_reg;

    logic [TAP_IDX_W-1:0]          tap_idx;
    logic [STEP_W-1:0]             fb_pos;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [HIST_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]      prod_next;
    bwiir_pkg::term_kind_t         kind_next;
    logic signed [PROD_W-1:0]      scale_sh;
    logic signed [HIST_W-1:0]      xs_sat;
    logic signed [PROD_W-1:0]      fb_sh;
    logic signed [ACC_W-1:0]       acc_next;
    logic signed [HIST_W-1:0]      y_sat;
    logic signed [HIST_W:0]        y_sh;
    logic [DATA_W-1:0]             out_next;

    // Operand selection: step 0 scales the input, steps 1..ORDER weight past
    // scaled inputs, the remaining steps weight past outputs.
    assign tap_idx = TAP_IDX_W'(step - 1'b1);
    assign fb_pos  = step - STEP_W'(ORDER + 1);

    always_comb begin
        mul_a     = '0;
        mul_b     = tap_reg[tap_idx];
        kind_next = bwiir_pkg::TERM_FEEDBACK;
        if (step == '0) begin
            mul_a     = {1'b0, gain_reg};
            mul_b     = {{(HIST_W - DATA_W){sample_reg[DATA_W-1]}}, sample_reg};
            kind_next = bwiir_pkg::TERM_SCALE;
        end else if (32'(step) <= 32'(ORDER)) begin
            mul_a     = {{(MUL_A_W - bwiir_pkg::BINOM_W){1'b0}},
                         bwiir_pkg::binom_weight(3'(ORDER), 3'(step))};
            kind_next = bwiir_pkg::TERM_BINOM;
        end else if (32'(fb_pos) < 32'(bwiir_pkg::NUM_FB)) begin
            mul_a = {coef_reg[fb_pos[1:0]][bwiir_pkg::COEF_W-1], coef_reg[fb_pos[1:0]]};
        end
    end

    assign prod_next = mul_a * mul_b;

    // Rounding of the registered product for the scale and feedback terms.
    assign scale_sh = (prod_reg + SCALE_HALF) >>> bwiir_pkg::SCALE_SHIFT;
    assign fb_sh    = (prod_reg + FB_HALF) >>> bwiir_pkg::FB_SHIFT;

    always_comb begin
        if (scale_sh > P_MAX) begin
            xs_sat = P_MAX[HIST_W-1:0];
        end else if (scale_sh < P_MIN) begin
            xs_sat = P_MIN[HIST_W-1:0];
        end else begin
            xs_sat = scale_sh[HIST_W-1:0];
        end
    end

    always_comb begin
        case (kind_reg)
            bwiir_pkg::TERM_SCALE: acc_next = {{(ACC_W - HIST_W){xs_sat[HIST_W-1]}}, xs_sat};
            bwiir_pkg::TERM_BINOM: acc_next = acc_reg + prod_reg[ACC_W-1:0];
            default:               acc_next = acc_reg + fb_sh[ACC_W-1:0];
        endcase
    end

    // Commit: the accumulator is saturated into the output history, then
    // rounded and saturated to the sample format.
    always_comb begin
        if (acc_reg > A_MAX) begin
            y_sat = A_MAX[HIST_W-1:0];
        end else if (acc_reg < A_MIN) begin
            y_sat = A_MIN[HIST_W-1:0];
        end else begin
            y_sat = acc_reg[HIST_W-1:0];
        end
    end

    assign y_sh = ($signed({y_sat[HIST_W-1], y_sat}) + OUT_HALF) >>> bwiir_pkg::OUT_SHIFT;

    always_comb begin
        if (y_sh > O_MAX) begin
            out_next = O_MAX[DATA_W-1:0];
        end else if (y_sh < O_MIN) begin
            out_next = O_MIN[DATA_W-1:0];
        end else begin
            out_next = y_sh[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= bwiir_pkg::GAIN_RESET;
            for (int i = 0; i < bwiir_pkg::NUM_FB; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_index)
                bwiir_pkg::REG_SCALE_GAIN: gain_reg    <= cfg_wdata;
                bwiir_pkg::REG_FB_COEF_1:  coef_reg[0] <= cfg_wdata;
                bwiir_pkg::REG_FB_COEF_2:  coef_reg[1] <= cfg_wdata;
                bwiir_pkg::REG_FB_COEF_3:  coef_reg[2] <= cfg_wdata;
                bwiir_pkg::REG_FB_COEF_4:  coef_reg[3] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // History taps: entries 0..ORDER-1 hold scaled inputs, the rest outputs,
    // newest first in each half.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TAPS; i++) begin
                tap_reg[i] <= '0;
            end
        end else if (cmd.commit) begin
            for (int i = ORDER - 1; i > 0; i--) begin
                tap_reg[i]         <= tap_reg[i - 1];
                tap_reg[ORDER + i] <= tap_reg[ORDER + i - 1];
            end
            tap_reg[0]     <= xs_reg;
            tap_reg[ORDER] <= y_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sample_reg <= s_data;
        end
        if (cmd.issue) begin
            prod_reg <= prod_next;
            kind_reg <= kind_next;
        end
        if (cmd.accum) begin
            acc_reg <= acc_next;
            if (kind_reg == bwiir_pkg::TERM_SCALE) begin
                xs_reg <= xs_sat;
            end
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

// ----- rtl/core/butterworth_iir_lowpass.sv -----
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+-----------------------------------
// s_        | in        | s_tvalid / s_tready | s_tdata[15:0] sample_in, Q1.15
// m_        | out       | m_tvalid / m_tready | m_tdata[15:0] sample_out, Q1.15
// cfg_      | in        | cfg_we              | cfg_index, cfg_wdata[31:0]
//
// One shared 33x32 multiplier handles the 2*ORDER + 1 products of a request in turn,
// followed by a drain state and a commit state.
// Reset is synchronous and active low; it clears the histories and loads register defaults.
// A new request is accepted while the previous result still waits in the output register.
// The commit stalls while that register holds a result not yet taken.
module butterworth_iir_lowpass #(
    parameter int ORDER = bwiir_pkg::ORDER_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,   // [15:0] sample_in
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [15:0]                          m_tdata,   // [15:0] sample_out
    input  logic                                 cfg_we,
    input  logic [bwiir_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bwiir_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int STEP_W = $clog2(2 * ORDER + 1);

    bwiir_pkg::cmd_t    cmd;
    logic [STEP_W-1:0]  step;

    bwiir_ctrl #(
        .ORDER(ORDER)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .step     (step)
    );

    bwiir_dp #(
        .ORDER(ORDER)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .step      (step),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_tdata),
        .m_data    (m_tdata)
    );

endmodule
